### design/rfb_pkg.sv
// shared types, constants and byte helpers for the rotated frame buffer
// no dependencies; used by the mapper, the top level and the checker
`default_nettype none

package rfb_pkg;

  localparam int unsigned PANEL_WIDTH_DEF  = 128;
  localparam int unsigned PANEL_HEIGHT_DEF = 250;

  localparam logic [7:0] BYTE_BLACK = 8'hFF;
  localparam logic [7:0] BYTE_WHITE = 8'h00;
  localparam logic [7:0] MASK_MSB   = 8'h80;

  typedef enum logic [1:0] {
    OP_PLOT = 2'd0,
    OP_FILL = 2'd1,
    OP_SCAN = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  // panel wants lsb first and inverted polarity
  function automatic logic [7:0] panel_format(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = b[i];
    end
    return ~r;
  endfunction

endpackage

`default_nettype wire

### design/rotated_framebuffer_plot_scanout_top.sv
// top level of the rotated one-bit frame buffer: control sequencer, scan counters, output stage
// uses rfb_pkg, rfb_map and rfb_store
`default_nettype none

// One-bit-per-pixel frame store for a monochrome panel, with drawing in four rotations and a
// byte-wise scan-out. Items are handled one at a time through a single store memory with a
// registered read. An on-screen plot or a scan item passes through acceptance with address
// mapping, memory read, and write-back or output load; an off-screen plot ends after the
// read and an unused operation at acceptance. A fill item sweeps the store at one byte per
// cycle. After reset the same sweep clears the store to white, so s_axis_tready stays low
// until that sweep is done; configuration writes are taken at any time. A scan result
// waits in an output register, and a scan item finding that register still full holds in its
// output-load state until the result is taken.
module rotated_framebuffer_plot_scanout_top #(
  parameter int unsigned PANEL_WIDTH  = rfb_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = rfb_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_data_i,     // rotation
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], is_white[32], zeros
  input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // panel_byte[7:0]
  output logic             m_axis_tlast    // frame_end
);

  localparam int unsigned RB    = (PANEL_WIDTH + 7) / 8;
  localparam int unsigned STORE = RB * PANEL_HEIGHT;
  localparam int unsigned AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int unsigned CBW   = (RB > 1) ? $clog2(RB) : 1;
  localparam int unsigned RWW   = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

  rfb_pkg::state_e state_q, state_d;
  rfb_pkg::op_e    op_q, in_op;

  logic            in_acc;
  logic            white_q;
  logic [1:0]      rot_q;
  logic [7:0]      fill_val_q;
  logic [AW-1:0]   sweep_q;
  logic            sweep_done;

  logic            map_hit;
  logic [AW-1:0]   map_addr;
  logic [7:0]      map_mask;

  logic [CBW-1:0]  scan_col_q;
  logic [RWW-1:0]  scan_row_q;
  logic [AW-1:0]   scan_base_q;
  logic [AW-1:0]   scan_addr;
  logic            scan_last;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata;

  logic            out_load;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  assign in_op      = rfb_pkg::op_e'(s_axis_tuser);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign sweep_done = (sweep_q == AW'(STORE - 1));
  assign scan_addr  = scan_base_q + AW'(RB - 1) - AW'(scan_col_q);
  assign scan_last  = (scan_row_q == RWW'(PANEL_HEIGHT - 1)) && (scan_col_q == CBW'(RB - 1));

  rfb_map #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .AW           (AW)
  ) u_map (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .rot_i   (rot_q),
    .pos_x_i (s_axis_tdata[15:0]),
    .pos_y_i (s_axis_tdata[31:16]),
    .hit_o   (map_hit),
    .addr_o  (map_addr),
    .mask_o  (map_mask)
  );

  rfb_store #(
    .DEPTH (STORE),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfb_pkg::ST_SWEEP: begin
        if (sweep_done) state_d = rfb_pkg::ST_IDLE;
      end
      rfb_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            rfb_pkg::OP_PLOT, rfb_pkg::OP_SCAN: state_d = rfb_pkg::ST_READ;
            rfb_pkg::OP_FILL:                   state_d = rfb_pkg::ST_SWEEP;
            default:                            state_d = rfb_pkg::ST_IDLE;
          endcase
        end
      end
      rfb_pkg::ST_READ: begin
        if (op_q == rfb_pkg::OP_PLOT && !map_hit) state_d = rfb_pkg::ST_IDLE;
        else                                      state_d = rfb_pkg::ST_WRITE;
      end
      rfb_pkg::ST_WRITE: begin
        if (op_q == rfb_pkg::OP_SCAN && out_valid_q && !m_axis_tready) begin
          state_d = rfb_pkg::ST_WRITE;
        end else begin
          state_d = rfb_pkg::ST_IDLE;
        end
      end
      default: state_d = rfb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = sweep_q;
    mem_wdata     = fill_val_q;
    mem_re        = 1'b0;
    mem_raddr     = scan_addr;
    out_load      = 1'b0;
    unique case (state_q)
      rfb_pkg::ST_SWEEP: begin
        mem_we = 1'b1;
      end
      rfb_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      rfb_pkg::ST_READ: begin
        mem_re    = (op_q == rfb_pkg::OP_SCAN) || map_hit;
        mem_raddr = (op_q == rfb_pkg::OP_PLOT) ? map_addr : scan_addr;
      end
      rfb_pkg::ST_WRITE: begin
        if (op_q == rfb_pkg::OP_PLOT) begin
          mem_we    = 1'b1;
          mem_waddr = map_addr;
          mem_wdata = white_q ? (mem_rdata & ~map_mask) : (mem_rdata | map_mask);
        end else begin
          out_load = !out_valid_q || m_axis_tready;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rfb_pkg::ST_SWEEP;
      sweep_q    <= '0;
      fill_val_q <= rfb_pkg::BYTE_WHITE;
      op_q       <= rfb_pkg::OP_NOP;
      white_q    <= 1'b0;
      rot_q      <= 2'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) rot_q <= cfg_data_i;
      if (state_q == rfb_pkg::ST_SWEEP) begin
        sweep_q <= sweep_done ? '0 : sweep_q + AW'(1);
      end
      if (in_acc) begin
        op_q       <= in_op;
        white_q    <= s_axis_tdata[32];
        fill_val_q <= s_axis_tdata[32] ? rfb_pkg::BYTE_WHITE : rfb_pkg::BYTE_BLACK;
      end
    end
  end

  // scan position: column counts right to left inside a row via scan_addr
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col_q  <= '0;
      scan_row_q  <= '0;
      scan_base_q <= '0;
    end else if (out_load) begin
      if (scan_last) begin
        scan_col_q  <= '0;
        scan_row_q  <= '0;
        scan_base_q <= '0;
      end else if (scan_col_q == CBW'(RB - 1)) begin
        scan_col_q  <= '0;
        scan_row_q  <= scan_row_q + RWW'(1);
        scan_base_q <= scan_base_q + AW'(RB);
      end else begin
        scan_col_q <= scan_col_q + CBW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= rfb_pkg::panel_format(mem_rdata);
      out_last_q <= scan_last;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### design/rfb_map.sv
// plot coordinate mapper: clip to the rotated size, rotate, form byte address and bit mask
// uses rfb_pkg; results are registered on en_i
`default_nettype none

module rfb_map #(
  parameter int unsigned PANEL_WIDTH  = rfb_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = rfb_pkg::PANEL_HEIGHT_DEF,
  parameter int unsigned AW           = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [1:0]           rot_i,
  input  wire logic signed [15:0]   pos_x_i,
  input  wire logic signed [15:0]   pos_y_i,
  output logic                      hit_o,
  output logic [AW-1:0]             addr_o,
  output logic [7:0]                mask_o
);

  localparam int unsigned RB = (PANEL_WIDTH + 7) / 8;
  localparam int unsigned XW = $clog2(PANEL_WIDTH);
  localparam int unsigned YW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

  logic signed [15:0] w_s, h_s;
  logic               in_range;
  logic [15:0]        px16, py16;
  logic [XW-1:0]      px;
  logic [YW-1:0]      py;
  logic [AW-1:0]      addr_d;
  logic [7:0]         mask_d;
  logic               hit_q;
  logic [AW-1:0]      addr_q;
  logic [7:0]         mask_q;

  always_comb begin
    w_s = rot_i[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
    h_s = rot_i[0] ? 16'(PANEL_WIDTH)  : 16'(PANEL_HEIGHT);
    in_range = !pos_x_i[15] && !pos_y_i[15] && (pos_x_i < w_s) && (pos_y_i < h_s);
    case (rot_i)
      2'd1: begin
        px16 = 16'(PANEL_WIDTH - 1) - pos_y_i;
        py16 = pos_x_i;
      end
      2'd2: begin
        px16 = 16'(PANEL_WIDTH - 1) - pos_x_i;
        py16 = 16'(PANEL_HEIGHT - 1) - pos_y_i;
      end
      2'd3: begin
        px16 = pos_y_i;
        py16 = 16'(PANEL_HEIGHT - 1) - pos_x_i;
      end
      default: begin
        px16 = pos_x_i;
        py16 = pos_y_i;
      end
    endcase
    px     = px16[XW-1:0];
    py     = py16[YW-1:0];
    addr_d = AW'(py * RB) + AW'(px >> 3);
    mask_d = rfb_pkg::MASK_MSB >> px[2:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= in_range;
      addr_q <= addr_d;
      mask_q <= mask_d;
    end
  end

  assign hit_o  = hit_q;
  assign addr_o = addr_q;
  assign mask_o = mask_q;

endmodule

`default_nettype wire

### design/rfb_store.sv
// frame store: one write port and one read port, read data registered
// no package dependency
`default_nettype none

module rfb_store #(
  parameter int unsigned DEPTH = 4000,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/rfb_checker.sv
// port-level checks for the rotated frame buffer, bound to the top level
// uses rfb_pkg for the operation codes
`default_nettype none

module rfb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a result held back by the sink stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // items that do work are handled one at a time; an unused operation is done at once
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser != 2'(rfb_pkg::OP_NOP) |=> !s_axis_tready)
    else $error("input accepted back to back");

  // a scan transaction into an empty output stage shows its result once it has passed the read and output-load states
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser == 2'(rfb_pkg::OP_SCAN) && !m_axis_tvalid |-> ##3 m_axis_tvalid)
    else $error("scan result missing");

  // plot, fill and unused transactions produce no result
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser != 2'(rfb_pkg::OP_SCAN) && !m_axis_tvalid |-> ##3 !m_axis_tvalid)
    else $error("unexpected result");

endmodule

bind rotated_framebuffer_plot_scanout_top rfb_checker u_rfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

### bench/rotated_framebuffer_plot_scanout_top_tb.sv
// self-checking bench for the rotated one-bit frame buffer: plots, fills and panel scan-out
// under all four rotations with random gaps on both streams; depends on rfb_pkg and the top
`default_nettype none

module rotated_framebuffer_plot_scanout_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfb_pkg::*;

  localparam int PANEL_W       = PANEL_WIDTH_DEF;
  localparam int PANEL_H       = PANEL_HEIGHT_DEF;
  localparam int ROW_BYTES     = (PANEL_W + 7) / 8;
  localparam int STORE_BYTES   = ROW_BYTES * PANEL_H;
  // a fill sweeps the whole store, so that bounds how long the block may still be busy
  localparam int SETTLE_CYCLES = STORE_BYTES + 16;
  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam int RANDOM_CHUNK  = 300;

  typedef struct packed {
    logic [7:0] panel_byte;
    logic       frame_end;
  } scan_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;     // pos_x[15:0], pos_y[31:16], is_white[32], zeros
  logic [1:0]  s_axis_tuser = OP_NOP; // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // panel_byte[7:0]
  logic        m_axis_tlast;          // frame_end

  // predicted contents of the frame store and scan position
  logic [7:0]  pix_mem [STORE_BYTES];
  int          scan_ptr = 0;
  logic [1:0]  cur_rot = 2'd0;
  scan_byte_t  expected_bytes_q[$];

  int          mismatch_count = 0;
  bit          idling_on = 1'b1;
  int          sink_hold = 0;

  rotated_framebuffer_plot_scanout_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void plot_pixel(logic signed [15:0] x, logic signed [15:0] y,
                                     logic white);
    int xs, ys, wr, hr, px, py, addr;
    logic [7:0] mask;
    xs = x;
    ys = y;
    wr = cur_rot[0] ? PANEL_H : PANEL_W;
    hr = cur_rot[0] ? PANEL_W : PANEL_H;
    if (xs < 0 || xs >= wr || ys < 0 || ys >= hr) return;
    case (cur_rot)
      2'd1: begin
        px = PANEL_W - ys - 1;
        py = xs;
      end
      2'd2: begin
        px = PANEL_W - xs - 1;
        py = PANEL_H - ys - 1;
      end
      2'd3: begin
        px = ys;
        py = PANEL_H - xs - 1;
      end
      default: begin
        px = xs;
        py = ys;
      end
    endcase
    addr = px / 8 + py * ROW_BYTES;
    if (addr >= STORE_BYTES) return;
    mask = MASK_MSB >> (px % 8);
    if (white) pix_mem[addr] = pix_mem[addr] & ~mask;
    else pix_mem[addr] = pix_mem[addr] | mask;
  endfunction

  function automatic void predict_frame_item(op_e op, logic [15:0] x, logic [15:0] y,
                                             logic white);
    int row, col;
    logic [7:0] stored, flipped;
    scan_byte_t res;
    case (op)
      OP_PLOT: plot_pixel(x, y, white);
      OP_FILL: begin
        for (int i = 0; i < STORE_BYTES; i++) pix_mem[i] = white ? BYTE_WHITE : BYTE_BLACK;
      end
      OP_SCAN: begin
        row = scan_ptr / ROW_BYTES;
        col = scan_ptr % ROW_BYTES;
        // right to left within a row
        stored = pix_mem[row * ROW_BYTES + ROW_BYTES - 1 - col];
        for (int i = 0; i < 8; i++) flipped[i] = stored[7 - i];
        res.panel_byte = ~flipped;
        res.frame_end = (scan_ptr == STORE_BYTES - 1);
        scan_ptr = res.frame_end ? 0 : scan_ptr + 1;
        expected_bytes_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(op_e op, int x, int y, logic white);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, white, 16'(y), 16'(x)};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame_item(op, 16'(x), 16'(y), white);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_rotation(logic [1:0] rot);
    wait_drained();
    // a plot or fill has no result, so give the block time to finish it
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rot;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_rot = rot;
  endtask

  // pick a panel pixel in the scan's current row or up to two rows ahead and map it back to drawing coordinates
  task automatic plot_near_scan(logic white);
    int px, py, x, y;
    py = (scan_ptr / ROW_BYTES + $urandom_range(0, 2)) % PANEL_H;
    px = $urandom_range(0, PANEL_W - 1);
    case (cur_rot)
      2'd1: begin
        x = py;
        y = PANEL_W - 1 - px;
      end
      2'd2: begin
        x = PANEL_W - 1 - px;
        y = PANEL_H - 1 - py;
      end
      2'd3: begin
        x = PANEL_H - 1 - py;
        y = px;
      end
      default: begin
        x = px;
        y = py;
      end
    endcase
    send_item(OP_PLOT, x, y, white);
  endtask

  task automatic test_basic_ops();
    // cleared to white by the reset sweep
    send_item(OP_SCAN, 0, 0, 1'b0);
    send_item(OP_SCAN, 0, 0, 1'b0);
    send_item(OP_PLOT, 127, 0, 1'b0);
    send_item(OP_PLOT, 103, 0, 1'b0);
    send_item(OP_PLOT, 96, 0, 1'b0);
    send_item(OP_PLOT, 103, 0, 1'b1);
    send_item(OP_SCAN, 0, 0, 1'b0);
    // off-screen plots and an unused operation change nothing; then plots on the bottom corners
    send_item(OP_PLOT, -1, 0, 1'b0);
    send_item(OP_PLOT, PANEL_W, 0, 1'b0);
    send_item(OP_PLOT, 0, PANEL_H, 1'b0);
    send_item(OP_PLOT, 0, -1, 1'b0);
    send_item(OP_PLOT, -32768, 32767, 1'b0);
    send_item(OP_PLOT, 32767, -32768, 1'b0);
    send_item(OP_NOP, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(OP_PLOT, 0, PANEL_H - 1, 1'b0);
    send_item(OP_PLOT, PANEL_W - 1, PANEL_H - 1, 1'b0);
    // fills in the middle of a frame scan keep the scan position
    send_item(OP_FILL, 0, 0, 1'b0);
    send_item(OP_SCAN, 0, 0, 1'b0);
    send_item(OP_PLOT, 88, 0, 1'b1);
    send_item(OP_SCAN, 0, 0, 1'b0);
    send_item(OP_FILL, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(OP_SCAN, 0, 0, 1'b0);
  endtask

  task automatic test_rotations();
    logic [1:0] rots [4] = '{2'd1, 2'd2, 2'd3, 2'd0};
    int w, h;
    foreach (rots[i]) begin
      set_rotation(rots[i]);
      w = rots[i][0] ? PANEL_H : PANEL_W;
      h = rots[i][0] ? PANEL_W : PANEL_H;
      send_item(OP_PLOT, 0, 0, 1'b0);
      send_item(OP_PLOT, w - 1, h - 1, 1'b0);
      send_item(OP_PLOT, w, 0, 1'b0);
      send_item(OP_PLOT, 0, h, 1'b0);
      send_item(OP_SCAN, 0, 0, 1'b0);
    end
  endtask

  task automatic test_random_mix();
    logic [1:0] chunk_rot [6] = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd0};
    int r;
    foreach (chunk_rot[c]) begin
      set_rotation(chunk_rot[c]);
      repeat (RANDOM_CHUNK) begin
        r = $urandom_range(0, 999);
        if (r < 400) send_item(OP_SCAN, $urandom, $urandom, 1'($urandom));
        else if (r < 750) plot_near_scan(1'($urandom));
        else if (r < 850)
          send_item(OP_PLOT, $urandom_range(0, PANEL_H - 1), $urandom_range(0, PANEL_H - 1),
                    1'($urandom));
        else if (r < 940) send_item(OP_PLOT, $urandom, $urandom, 1'($urandom));
        else if (r < 994) send_item(OP_NOP, $urandom, $urandom, 1'($urandom));
        else send_item(OP_FILL, $urandom, $urandom, 1'($urandom));
      end
    end
  endtask

  // result side: random stalls with ready-always stretches between them
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_hold <= gap_cycles();
    end
  end

  always @(posedge clk_i) begin
    scan_byte_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected panel byte %02h last %0b", m_axis_tdata, m_axis_tlast);
      end else begin
        exp_b = expected_bytes_q.pop_front();
        if (m_axis_tdata !== exp_b.panel_byte || m_axis_tlast !== exp_b.frame_end) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("panel byte mismatch: expected %02h last %0b, got %02h last %0b",
                     exp_b.panel_byte, exp_b.frame_end, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("rotated_framebuffer_plot_scanout_top test failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) pix_mem[i] = BYTE_WHITE;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_ops();
    test_rotations();
    test_random_mix();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rotated_framebuffer_plot_scanout_top test passed");
    end else begin
      $display("rotated_framebuffer_plot_scanout_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
